### src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DW   = 32;          // width of one part
	localparam int FB   = 16;          // fraction bits
	localparam int PW   = 2 * DW;      // full product width
	localparam int WW   = PW + 2;      // wide signed work width
	localparam int RW   = PW + FB;     // divider remainder width
	localparam int DSW  = PW + DW;     // shifted divisor width
	localparam int CW   = $clog2(DW);  // divider step counter width

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	typedef struct packed {
		logic [1:0]           kind;
		logic signed [DW-1:0] a_real;
		logic signed [DW-1:0] a_imag;
		logic signed [DW-1:0] b_real;
		logic signed [DW-1:0] b_imag;
	} cau_in_t;

	typedef struct packed {
		logic signed [DW-1:0] res_real;
		logic signed [DW-1:0] res_imag;
		logic [1:0]           status;
	} cau_out_t;

	// queued item with its classification
	typedef struct packed {
		cau_in_t data;
		logic    b_zero;
	} cau_item_t;

	typedef struct packed {
		logic [DW-1:0] val;
		logic          sat;
	} cau_sat_t;

	localparam logic signed [WW-1:0] SMAX = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [WW-1:0] SMIN = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	function automatic cau_sat_t saturate(input logic signed [WW-1:0] v);
		cau_sat_t r;
		if (v > SMAX) begin
			r.val = SMAX[DW-1:0];
			r.sat = 1'b1;
		end else if (v < SMIN) begin
			r.val = SMIN[DW-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = v[DW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

### src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Accepts items, flags a zero divisor and queues them for the back end.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cau_pkg::cau_in_t   op,
	output logic               head_valid,
	output cau_pkg::cau_item_t head,
	input  logic               pop
);
	import cau_pkg::*;

	cau_item_t      mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           do_pop;
	cau_item_t      item;

	assign busy       = (count_q == (QAW+1)'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_q];

	always_comb begin
		item.data   = op;
		item.b_zero = (op.b_real == '0) && (op.b_imag == '0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Executes queued items: add/sub at once, multiply over a product stage,
// divide by a two-lane restoring divider.
// ----------------------------------------------------------------------------
module cau_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  cau_pkg::cau_item_t head,
	output logic               pop,
	output cau_pkg::cau_out_t  res,
	output logic               done
);
	import cau_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PROD, S_SUM, S_DIV, S_FIN} state_t;

	state_t                state_q;
	cau_item_t             item_q;
	logic signed [PW-1:0]  ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
	logic [PW-1:0]         den_q;
	logic [RW-1:0]         rem_re_q, rem_im_q;
	logic [DSW-1:0]        dsh_q;
	logic [DW-1:0]         q_re_q, q_im_q;
	logic                  neg_re_q, neg_im_q;
	logic                  ovf_re_q, ovf_im_q;
	logic [CW-1:0]         cnt_q;
	cau_out_t              res_q;
	logic                  done_q;

	logic signed [WW-1:0]  sum_re, sum_im;
	cau_sat_t              add_re, add_im, mul_re, mul_im;
	logic signed [WW-1:0]  num_re, num_im;
	logic [PW-1:0]         mag_re, mag_im;
	logic [PW-1:0]         den;
	logic                  ge_re, ge_im;
	cau_sat_t              dv_re, dv_im;
	logic [DSW-1:0]        den_top;

	function automatic cau_sat_t div_store(input logic [DW-1:0] q, input logic neg,
			input logic ovf);
		cau_sat_t      r;
		logic [DW-1:0] lim;
		logic [DW-1:0] mag;
		lim   = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		r.sat = ovf || (q > lim);
		mag   = r.sat ? lim : q;
		r.val = neg ? (~mag + 1'b1) : mag;
		return r;
	endfunction

	assign pop = (state_q == S_IDLE) && head_valid;

	// add and subtract straight from the queue head
	always_comb begin
		if (head.data.kind == KIND_SUB) begin
			sum_re = WW'(head.data.a_real) - WW'(head.data.b_real);
			sum_im = WW'(head.data.a_imag) - WW'(head.data.b_imag);
		end else begin
			sum_re = WW'(head.data.a_real) + WW'(head.data.b_real);
			sum_im = WW'(head.data.a_imag) + WW'(head.data.b_imag);
		end
		add_re = saturate(sum_re);
		add_im = saturate(sum_im);
	end

	// multiply: floor shift of the exact sums
	always_comb begin
		mul_re = saturate((WW'(ac_q) - WW'(bd_q)) >>> FB);
		mul_im = saturate((WW'(ad_q) + WW'(bc_q)) >>> FB);
	end

	// divide numerators and denominator
	always_comb begin
		num_re = WW'(ac_q) + WW'(bd_q);
		num_im = WW'(bc_q) - WW'(ad_q);
		mag_re = num_re[WW-1] ? PW'(-num_re) : PW'(num_re);
		mag_im = num_im[WW-1] ? PW'(-num_im) : PW'(num_im);
		den    = PW'(cc_q) + PW'(dd_q);
	end

	assign ge_re   = DSW'(rem_re_q) >= dsh_q;
	assign ge_im   = DSW'(rem_im_q) >= dsh_q;
	assign den_top = {den_q, {DW{1'b0}}};

	always_comb begin
		dv_re = div_store(q_re_q, neg_re_q, ovf_re_q);
		dv_im = div_store(q_im_q, neg_im_q, ovf_im_q);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (state_q == S_PROD) begin
			ac_q <= PW'(item_q.data.a_real * item_q.data.b_real);
			bd_q <= PW'(item_q.data.a_imag * item_q.data.b_imag);
			ad_q <= PW'(item_q.data.a_real * item_q.data.b_imag);
			bc_q <= PW'(item_q.data.a_imag * item_q.data.b_real);
			cc_q <= PW'(item_q.data.b_real * item_q.data.b_real);
			dd_q <= PW'(item_q.data.b_imag * item_q.data.b_imag);
		end
		if (state_q == S_SUM) begin
			den_q    <= den;
			rem_re_q <= {mag_re, {FB{1'b0}}};
			rem_im_q <= {mag_im, {FB{1'b0}}};
			dsh_q    <= DSW'({den, {(DW-1){1'b0}}});
			neg_re_q <= num_re[WW-1];
			neg_im_q <= num_im[WW-1];
		end
		if (state_q == S_DIV) begin
			if (cnt_q == CW'(DW-1)) begin
				// quotient needs more than DW bits
				ovf_re_q <= DSW'(rem_re_q) >= den_top;
				ovf_im_q <= DSW'(rem_im_q) >= den_top;
			end
			if (ge_re) begin
				rem_re_q <= rem_re_q - dsh_q[RW-1:0];
			end
			if (ge_im) begin
				rem_im_q <= rem_im_q - dsh_q[RW-1:0];
			end
			q_re_q <= {q_re_q[DW-2:0], ge_re};
			q_im_q <= {q_im_q[DW-2:0], ge_im};
			dsh_q  <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						if (head.data.kind == KIND_ADD || head.data.kind == KIND_SUB) begin
							done_q         <= 1'b1;
							res_q.res_real <= add_re.val;
							res_q.res_imag <= add_im.val;
							res_q.status   <= (add_re.sat || add_im.sat) ? ST_SAT : ST_OK;
						end else begin
							state_q <= S_PROD;
						end
					end
				end
				S_PROD: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (item_q.data.kind == KIND_MUL) begin
						done_q         <= 1'b1;
						res_q.res_real <= mul_re.val;
						res_q.res_imag <= mul_im.val;
						res_q.status   <= (mul_re.sat || mul_im.sat) ? ST_SAT : ST_OK;
						state_q        <= S_IDLE;
					end else if (item_q.b_zero) begin
						done_q  <= 1'b1;
						res_q   <= '{res_real: '0, res_imag: '0, status: ST_DZ};
						state_q <= S_IDLE;
					end else begin
						cnt_q   <= CW'(DW-1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q         <= 1'b1;
					res_q.res_real <= dv_re.val;
					res_q.res_imag <= dv_im.val;
					res_q.status   <= (dv_re.sat || dv_im.sat) ? ST_SAT : ST_OK;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.status != 2'd3) else $error("unused status code produced");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_DZ) |-> (res.res_real == '0 && res.res_imag == '0))
		else $error("divide by zero result not cleared");

	a_prod_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROD |=> state_q == S_SUM) else $error("product stage skipped");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> done) else $error("divide finished without result");

endmodule

### src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// add/sub pass the queue and result registers; multiply also item and product
// registers; divide also the set-up and steps of the bit-per-cycle divider
// (done loads with res); throughput: add/sub one item per cycle while idle;
// mul and div hold the sequencer until done; a 4-item queue absorbs bursts
// reset clears the queue, the sequencer and done; results cannot be stalled
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on Q16.16 operands.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cau_pkg::cau_in_t  op,
	output cau_pkg::cau_out_t res,
	output logic              done
);
	import cau_pkg::*;

	logic      head_valid;
	cau_item_t head;
	logic      pop;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res),
		.done       (done)
	);

endmodule

### dv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives complex add, subtract, multiply and divide items through the unit,
// with bursty start timing, and checks every result against a listed value
// or a wide-integer model of Q16.16 arithmetic, saturation and zero divisors.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int WATCHDOG = 4000;
	localparam logic signed [DW-1:0] PMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] PMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] ONE  = 32'sd65536;

	typedef struct {
		cau_in_t  item;
		bit       typed;
		cau_out_t want;
	} row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	cau_in_t  op;
	cau_out_t res;
	logic     done;

	cau_out_t expected_q[$];
	bit       cur_typed;
	cau_out_t cur_want;
	int       mismatches;
	int       results_seen;
	int       idle_cycles;
	int       n_sent;
	int       kind_cnt[4];
	int       sat_cnt;
	int       dz_cnt;

	complex_arithmetic_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.op    (op),
		.res   (res),
		.done  (done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic cau_out_t clamp_pair(logic signed [129:0] re, logic signed [129:0] im);
		cau_out_t r;
		logic     sat;
		sat = 1'b0;
		if (re > PMAX) begin
			r.res_real = PMAX; sat = 1'b1;
		end else if (re < PMIN) begin
			r.res_real = PMIN; sat = 1'b1;
		end else begin
			r.res_real = re[DW-1:0];
		end
		if (im > PMAX) begin
			r.res_imag = PMAX; sat = 1'b1;
		end else if (im < PMIN) begin
			r.res_imag = PMIN; sat = 1'b1;
		end else begin
			r.res_imag = im[DW-1:0];
		end
		r.status = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic cau_out_t complex_result(cau_in_t x);
		logic signed [129:0] ar, ai, br, bi, re, im, den;
		cau_out_t r;
		ar = 130'(x.a_real); ai = 130'(x.a_imag);
		br = 130'(x.b_real); bi = 130'(x.b_imag);
		case (x.kind)
			KIND_ADD: begin
				re = ar + br; im = ai + bi;
			end
			KIND_SUB: begin
				re = ar - br; im = ai - bi;
			end
			KIND_MUL: begin
				// arithmetic shift floors toward minus infinity
				re = (ar * br - ai * bi) >>> FB;
				im = (ar * bi + ai * br) >>> FB;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.res_real = '0; r.res_imag = '0; r.status = ST_DZ;
					return r;
				end
				// signed divide truncates toward zero
				re = ((ar * br + ai * bi) * 130'sd65536) / den;
				im = ((ai * br - ar * bi) * 130'sd65536) / den;
			end
		endcase
		return clamp_pair(re, im);
	endfunction

	function automatic logic [DW-1:0] rand_part();
		case ($urandom_range(0, 9))
			0: return PMAX;
			1: return PMIN;
			2: return '0;
			3: return $urandom_range(0, 3) - 2;
			4, 5, 6: return $signed($urandom_range(0, 16 * 65536)) - 8 * 65536;
			default: return $urandom;
		endcase
	endfunction

	// accept and check at the rising edge
	always @(posedge clk) begin
		cau_out_t e;
		if (arst_n) begin
			if (start && !busy) begin
				expected_q.push_back(cur_typed ? cur_want : complex_result(op));
				kind_cnt[op.kind]++;
			end
			if (done) begin
				results_seen++;
				if (res.status == ST_SAT) sat_cnt++;
				if (res.status == ST_DZ) dz_cnt++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with no item pending: %h %h %0d",
							res.res_real, res.res_imag, res.status);
				end else begin
					e = expected_q.pop_front();
					if (res !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %h %h %0d got %h %h %0d",
								e.res_real, e.res_imag, e.status,
								res.res_real, res.res_imag, res.status);
					end
				end
			end
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired, %0d items pending", expected_q.size());
				$display("tb_complex_arithmetic_unit: done, errors");
				$finish;
			end
		end
	end

	task automatic send_item(cau_in_t x, bit typed, cau_out_t want);
		int gap;
		@(negedge clk);
		start     <= 1'b1;
		op        <= x;
		cur_typed = typed;
		cur_want  = want;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
		// bursts: usually no gap, sometimes one of random length
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic row_t mk(logic [1:0] k, logic [DW-1:0] ar, logic [DW-1:0] ai,
			logic [DW-1:0] br, logic [DW-1:0] bi, bit typed = 1'b0,
			logic [DW-1:0] wr = '0, logic [DW-1:0] wi = '0, logic [1:0] ws = ST_OK);
		row_t r;
		r.item = '{k, ar, ai, br, bi};
		r.typed = typed;
		r.want = '{wr, wi, ws};
		return r;
	endfunction

	initial begin
		row_t     rows[$];
		cau_in_t  x;
		cau_out_t none;
		none = '0;
		mismatches = 0; results_seen = 0; idle_cycles = 0; n_sent = 0;
		sat_cnt = 0; dz_cnt = 0;
		foreach (kind_cnt[i]) kind_cnt[i] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows.push_back(mk(KIND_ADD, 0, 0, 0, 0, 1'b1, 0, 0, ST_OK));
		rows.push_back(mk(KIND_ADD, PMAX, PMIN, PMAX, PMIN, 1'b1, PMAX, PMIN, ST_SAT));
		rows.push_back(mk(KIND_SUB, PMIN, PMAX, PMAX, PMIN, 1'b1, PMIN, PMAX, ST_SAT));
		rows.push_back(mk(KIND_SUB, PMAX, PMIN, PMAX, PMIN, 1'b1, 0, 0, ST_OK));
		rows.push_back(mk(KIND_MUL, ONE, ONE, ONE, 0, 1'b1, ONE, ONE, ST_OK));
		rows.push_back(mk(KIND_MUL, PMIN, PMIN, PMIN, PMIN));
		rows.push_back(mk(KIND_MUL, PMAX, PMIN, PMIN, PMAX));
		rows.push_back(mk(KIND_MUL, -1, 1, 1, -1));
		rows.push_back(mk(KIND_MUL, -32'sd3, 0, 1, 0));
		rows.push_back(mk(KIND_DIV, ONE, ONE, 0, 0, 1'b1, 0, 0, ST_DZ));
		rows.push_back(mk(KIND_DIV, PMAX, PMIN, 0, 0, 1'b1, 0, 0, ST_DZ));
		rows.push_back(mk(KIND_DIV, ONE, 0, ONE, 0, 1'b1, ONE, 0, ST_OK));
		rows.push_back(mk(KIND_DIV, PMAX, PMAX, 1, 0, 1'b1, PMAX, PMAX, ST_SAT));
		rows.push_back(mk(KIND_DIV, PMIN, PMIN, PMIN, PMIN));
		rows.push_back(mk(KIND_DIV, PMAX, PMIN, PMIN, PMAX));
		rows.push_back(mk(KIND_DIV, -1, 1, 3 * ONE, -ONE));
		rows.push_back(mk(KIND_DIV, 0, 0, PMAX, PMIN, 1'b1, 0, 0, ST_OK));
		rows.push_back(mk(KIND_DIV, 7, -5, 0, 1));
		foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

		repeat (1900) begin
			x.kind   = 2'($urandom_range(0, 3));
			x.a_real = rand_part();
			x.a_imag = rand_part();
			x.b_real = rand_part();
			x.b_imag = rand_part();
			if (x.kind == KIND_DIV && $urandom_range(0, 15) == 0) begin
				x.b_real = '0; x.b_imag = '0;
			end
			send_item(x, 1'b0, none);
		end
		@(negedge clk);
		start <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("sent %0d items (add %0d sub %0d mul %0d div %0d), %0d results checked",
			n_sent, kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], results_seen);
		$display("saturated results %0d, divide by zero %0d, mismatches %0d",
			sat_cnt, dz_cnt, mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_complex_arithmetic_unit: done, clean");
		end else begin
			$display("tb_complex_arithmetic_unit: done, errors");
		end
		$finish;
	end

endmodule
